>>> hw/rtl/mfsk_pkg.sv
// ----------------------------------------------------------------------------
// mfsk_pkg
// shared types, segment codes and the sine table for the tone transmitter
// ----------------------------------------------------------------------------
package mfsk_pkg;

    localparam int MAX_TEXT     = 40;
    localparam int SINE_ENTRIES = 1024;
    localparam int IDX_W        = $clog2(SINE_ENTRIES);
    localparam int POS_W        = 6;

    // segment kinds
    localparam logic [2:0] K_IDLE = 3'd0;
    localparam logic [2:0] K_LEAD = 3'd1;
    localparam logic [2:0] K_SYNC = 3'd2;
    localparam logic [2:0] K_SGAP = 3'd3;
    localparam logic [2:0] K_DATA = 3'd4;
    localparam logic [2:0] K_DGAP = 3'd5;
    localparam logic [2:0] K_END  = 3'd6;
    localparam logic [2:0] K_TAIL = 3'd7;

    // configuration register indexes
    localparam logic [2:0] R_TONE = 3'd0;
    localparam logic [2:0] R_GAP  = 3'd1;
    localparam logic [2:0] R_SYNC = 3'd2;
    localparam logic [2:0] R_RAMP = 3'd3;
    localparam logic [2:0] R_LEAD = 3'd4;
    localparam logic [2:0] R_TAIL = 3'd5;
    localparam logic [2:0] R_PPHZ = 3'd6;
    localparam logic [2:0] R_MAX  = 3'd7;

    localparam logic [13:0] AMPL = 14'd9000;

    // sample job handed from the sequencer to the sample unit
    typedef struct packed {
        logic        tone;
        logic [31:0] phase;
        logic [16:0] num;
        logic [15:0] den;
        logic        last;
    } job_t;

    // quarter-wave polynomial, Q30, truncating steps and a rounded Q15 result like the fixed-point spec
    function automatic logic [14:0] quarter_sine(input logic [30:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] q;
        x2 = (64'(x) * 64'(x)) >> 30;
        p  = 64'd5026995 - ((x2 * 64'd172271) >> 30);
        p  = 64'd85569306 - ((x2 * p) >> 30);
        p  = 64'd693598668 - ((x2 * p) >> 30);
        p  = 64'd1686629713 - ((x2 * p) >> 30);
        s  = (64'(x) * p) >> 30;
        q  = (s + 64'd16384) >> 15;
        return (q > 64'd32767) ? 15'h7fff : q[14:0];
    endfunction

    // signed Q2.15 table entry, elaborated as constant logic
    function automatic logic signed [16:0] sine_entry(input logic [IDX_W-1:0] idx);
        logic [IDX_W+1:0] u;
        logic [1:0]       quad;
        logic [63:0]      rem;
        logic [63:0]      x;
        logic [14:0]      m;
        u    = {idx, 2'b00};
        quad = u[IDX_W+1:IDX_W];
        rem  = 64'(u[IDX_W-1:0]);
        x    = (rem << 30) / SINE_ENTRIES;
        if (quad[0]) x = 64'd1073741824 - x;
        m = quarter_sine(x[30:0]);
        return quad[1] ? -$signed({2'b00, m}) : $signed({2'b00, m});
    endfunction

endpackage

>>> hw/rtl/mfsk_tone_transmitter.sv
// ----------------------------------------------------------------------------
// mfsk_tone_transmitter
// 16-tone mfsk modulator: load message bytes, then one pcm sample per tick
// ----------------------------------------------------------------------------
// channel   dir  signals                         request
// s_        in   s_tvalid/s_tready/s_tdata/tuser  tuser=func, tdata=data_byte
// m_        out  m_tvalid/m_tready/m_tdata/tlast  tdata=sample, tlast=last
// cfg_      in   cfg_valid/cfg_ready/index/data   register write
//
// a tick request runs the sequencer states ST_FRQ, ST_EMIT and ST_SKIP, then the 46
// step restoring divide by the ramp length in the sample unit
// ST_SKIP walks past each empty segment in turn
// reset (aresetn low, synchronous) clears all control
// the finished sample sits in an output register, so the sequencer works on
// the next request while the result waits for m_tready
// ----------------------------------------------------------------------------
module mfsk_tone_transmitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [14:0] sample, [15] zero fill
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] tone_len_reg, gap_len_reg, sync_len_reg, ramp_len_reg;
    logic [15:0] lead_len_reg, tail_len_reg;
    logic [31:0] pphz_reg;
    logic [23:0] max_reg;
    logic        job_valid;
    logic        job_ready;
    mfsk_pkg::job_t job;
    logic [14:0] sample;

    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_len_reg <= 16'd800;
            gap_len_reg  <= 16'd320;
            sync_len_reg <= 16'd2400;
            ramp_len_reg <= 16'd40;
            lead_len_reg <= 16'd400;
            tail_len_reg <= 16'd1600;
            pphz_reg     <= 32'd536871;
            max_reg      <= 24'hffffff;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mfsk_pkg::R_TONE: tone_len_reg <= cfg_data[15:0];
                mfsk_pkg::R_GAP:  gap_len_reg  <= cfg_data[15:0];
                mfsk_pkg::R_SYNC: sync_len_reg <= cfg_data[15:0];
                mfsk_pkg::R_RAMP: ramp_len_reg <= cfg_data[15:0];
                mfsk_pkg::R_LEAD: lead_len_reg <= cfg_data[15:0];
                mfsk_pkg::R_TAIL: tail_len_reg <= cfg_data[15:0];
                mfsk_pkg::R_PPHZ: pphz_reg     <= cfg_data;
                mfsk_pkg::R_MAX:  max_reg      <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // front end: request sequencing and segment walk
    mfsk_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_func      (s_tuser),
        .in_byte      (s_tdata),
        .tone_len     (tone_len_reg),
        .gap_len      (gap_len_reg),
        .sync_len     (sync_len_reg),
        .ramp_len     (ramp_len_reg),
        .lead_len     (lead_len_reg),
        .tail_len     (tail_len_reg),
        .phase_per_hz (pphz_reg),
        .max_samples  (max_reg),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    // back end: sample arithmetic and output register
    mfsk_smp u_smp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_sample  (sample),
        .m_last    (m_tlast)
    );

    assign m_tdata = {1'b0, sample};

endmodule

>>> hw/rtl/mfsk_seq.sv
// ----------------------------------------------------------------------------
// mfsk_seq
// front end: takes loads and ticks, walks the segment order, emits sample jobs
// ----------------------------------------------------------------------------
module mfsk_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_func,
    input  logic [7:0]          in_byte,
    input  logic [15:0]         tone_len,
    input  logic [15:0]         gap_len,
    input  logic [15:0]         sync_len,
    input  logic [15:0]         ramp_len,
    input  logic [15:0]         lead_len,
    input  logic [15:0]         tail_len,
    input  logic [31:0]         phase_per_hz,
    input  logic [23:0]         max_samples,
    output logic                job_valid,
    input  logic                job_ready,
    output mfsk_pkg::job_t      job
);

    // ST_ACC takes an item, ST_SKIP walks past empty segments and raises the job,
    // ST_FRQ waits for the message byte read, ST_EMIT builds the job and advances
    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_FRQ  = 2'd3;

    logic [7:0]  mem [mfsk_pkg::MAX_TEXT];
    logic [7:0]  rd_reg;
    logic [1:0]  st_reg;
    logic [2:0]  kind_reg;
    logic [5:0]  mlen_reg;
    logic [5:0]  pos_reg;
    logic        low_reg;
    logic [15:0] cnt_reg;
    logic [23:0] tot_reg;
    logic [31:0] ph_reg;
    logic        after_reg; // skip run follows an emitted sample
    mfsk_pkg::job_t job_reg;

    logic [15:0] seg_len;
    logic        mem_wr;
    logic [2:0]  nk;
    logic [5:0]  npos;
    logic        nlow;
    logic [16:0] cnt_inc;
    logic [11:0] freq;
    logic [3:0]  nib;
    logic [16:0] num;

    always_comb begin
        case (kind_reg)
            mfsk_pkg::K_LEAD: seg_len = lead_len;
            mfsk_pkg::K_SYNC: seg_len = sync_len;
            mfsk_pkg::K_SGAP: seg_len = gap_len;
            mfsk_pkg::K_DATA: seg_len = tone_len;
            mfsk_pkg::K_DGAP: seg_len = gap_len;
            mfsk_pkg::K_END:  seg_len = tone_len;
            mfsk_pkg::K_TAIL: seg_len = tail_len;
            default:          seg_len = 16'd0;
        endcase
    end

    always_comb begin
        npos = pos_reg;
        nlow = low_reg;
        case (kind_reg)
            mfsk_pkg::K_LEAD: nk = mfsk_pkg::K_SYNC;
            mfsk_pkg::K_SYNC: nk = mfsk_pkg::K_SGAP;
            mfsk_pkg::K_SGAP: begin
                npos = 6'd0;
                nlow = 1'b0;
                nk   = (mlen_reg != 6'd0) ? mfsk_pkg::K_DATA : mfsk_pkg::K_END;
            end
            mfsk_pkg::K_DATA: nk = mfsk_pkg::K_DGAP;
            mfsk_pkg::K_DGAP: begin
                if (low_reg) begin
                    nlow = 1'b0;
                    npos = pos_reg + 6'd1;
                    nk   = (npos < mlen_reg) ? mfsk_pkg::K_DATA : mfsk_pkg::K_END;
                end else begin
                    nlow = 1'b1;
                    nk   = mfsk_pkg::K_DATA;
                end
            end
            mfsk_pkg::K_END:  nk = mfsk_pkg::K_TAIL;
            default:          nk = mfsk_pkg::K_IDLE;
        endcase
    end

    assign nib  = low_reg ? rd_reg[3:0] : rd_reg[7:4];
    assign freq = (kind_reg == mfsk_pkg::K_SYNC) ? 12'd1350 :
                  (kind_reg == mfsk_pkg::K_END)  ? 12'd1200 :
                  12'(12'd1500 + 12'd90 * 12'(nib));

    always_comb begin
        if (ramp_len == 16'd0)              num = 17'd1;
        else if (cnt_reg < ramp_len)        num = {1'b0, cnt_reg};
        else if ({1'b0, cnt_reg} + {1'b0, ramp_len} > {1'b0, seg_len}) begin
            num = (cnt_reg >= seg_len) ? 17'd0 : 17'(seg_len - cnt_reg);
        end else                            num = {1'b0, ramp_len};
    end

    assign cnt_inc  = {1'b0, cnt_reg} + 17'd1;
    assign in_ready = (st_reg == ST_ACC) && !job_valid;
    assign mem_wr   = in_valid && in_ready && !in_func && kind_reg == mfsk_pkg::K_IDLE
                      && mlen_reg < 6'(mfsk_pkg::MAX_TEXT);

    always_ff @(posedge aclk) begin
        if (mem_wr) mem[mlen_reg] <= in_byte;
        rd_reg <= mem[(pos_reg < 6'(mfsk_pkg::MAX_TEXT)) ? pos_reg : 6'd0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_ACC;
            kind_reg  <= mfsk_pkg::K_IDLE;
            mlen_reg  <= 6'd0;
            pos_reg   <= 6'd0;
            low_reg   <= 1'b0;
            cnt_reg   <= 16'd0;
            tot_reg   <= 24'd0;
            ph_reg    <= 32'd0;
            after_reg <= 1'b0;
            job_valid <= 1'b0;
        end else begin
            if (job_valid && job_ready) job_valid <= 1'b0;
            case (st_reg)
                ST_ACC: begin
                    if (in_valid && in_ready) begin
                        if (!in_func) begin
                            if (mem_wr) mlen_reg <= mlen_reg + 6'd1;
                        end else if (kind_reg == mfsk_pkg::K_IDLE) begin
                            kind_reg  <= mfsk_pkg::K_LEAD;
                            pos_reg   <= 6'd0;
                            low_reg   <= 1'b0;
                            cnt_reg   <= 16'd0;
                            tot_reg   <= 24'd0;
                            ph_reg    <= 32'd0;
                            after_reg <= 1'b0;
                            st_reg    <= ST_SKIP;
                        end else begin
                            after_reg <= 1'b0;
                            st_reg    <= ST_FRQ;
                        end
                    end
                end
                ST_SKIP: begin
                    if (kind_reg != mfsk_pkg::K_IDLE && seg_len == 16'd0) begin
                        kind_reg <= nk;
                        pos_reg  <= npos;
                        low_reg  <= nlow;
                    end else if (after_reg) begin
                        // end of a sample's bookkeeping: decide last
                        if (kind_reg == mfsk_pkg::K_IDLE || tot_reg >= max_samples) begin
                            kind_reg      <= mfsk_pkg::K_IDLE;
                            mlen_reg      <= 6'd0;
                            cnt_reg       <= 16'd0;
                            ph_reg        <= 32'd0;
                            job_reg.last  <= 1'b1;
                        end else begin
                            job_reg.last  <= 1'b0;
                        end
                        job_valid <= 1'b1;
                        st_reg    <= ST_ACC;
                    end else if (kind_reg == mfsk_pkg::K_IDLE || max_samples == 24'd0) begin
                        kind_reg <= mfsk_pkg::K_IDLE;
                        mlen_reg <= 6'd0;
                        st_reg   <= ST_ACC;
                    end else begin
                        st_reg <= ST_FRQ;
                    end
                end
                ST_FRQ: st_reg <= ST_EMIT;
                default: begin
                    // build the job from the current segment, then advance
                    job_reg.tone  <= kind_reg == mfsk_pkg::K_SYNC ||
                                     kind_reg == mfsk_pkg::K_DATA ||
                                     kind_reg == mfsk_pkg::K_END;
                    job_reg.phase <= ph_reg;
                    job_reg.num   <= num;
                    job_reg.den   <= (ramp_len == 16'd0) ? 16'd1 : ramp_len;
                    tot_reg       <= tot_reg + 24'd1;
                    after_reg     <= 1'b1;
                    if (cnt_inc >= {1'b0, seg_len}) begin
                        kind_reg <= nk;
                        pos_reg  <= npos;
                        low_reg  <= nlow;
                        cnt_reg  <= 16'd0;
                        ph_reg   <= 32'd0;
                    end else begin
                        cnt_reg <= cnt_inc[15:0];
                        ph_reg  <= ph_reg + 32'(freq) * phase_per_hz;
                    end
                    st_reg <= ST_SKIP;
                end
            endcase
        end
    end

    assign job = job_reg;

`ifndef SYNTHESIS
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        mlen_reg <= 6'(mfsk_pkg::MAX_TEXT)) else $error("message length over capacity");
    a_idle_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job.last |-> kind_reg == mfsk_pkg::K_IDLE)
        else $error("last job while transmission live");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg == mfsk_pkg::K_IDLE |-> cnt_reg == 16'd0)
        else $error("sample count not cleared");
`endif

endmodule

>>> hw/rtl/mfsk_smp.sv
// ----------------------------------------------------------------------------
// mfsk_smp
// back end: sine lookup, amplitude multiply and restoring divide by ramp
// ----------------------------------------------------------------------------
module mfsk_smp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  mfsk_pkg::job_t      job,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [14:0]         m_sample,
    output logic                m_last
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    // dividend = mag*9000*num < 2^15 * 2^14 * 2^17, divisor = den << 15
    localparam int DV_W = 46;

    // quarter-wave table: index bits below the quadrant
    localparam int QW  = mfsk_pkg::IDX_W - 2;
    localparam int QTR = 1 << QW;
    localparam logic [QW:0]  QTR_V = {1'b1, {QW{1'b0}}};
    localparam logic [14:0]  Q_TOP = mfsk_pkg::quarter_sine(31'h4000_0000);

    logic [1:0]            st_reg;
    logic                  neg_reg;
    logic                  tone_reg;
    logic                  last_reg;
    logic [28:0]           prod_reg;
    logic [16:0]           num_reg;
    logic [15:0]           den_reg;
    logic [DV_W-1:0]       rem_reg;
    logic [DV_W-1:0]       quo_reg;
    logic [5:0]            bit_reg;
    logic [14:0]           qtab [QTR];
    logic [mfsk_pkg::IDX_W-1:0] idx;
    logic [QW:0]           fold;
    logic [14:0]           mq;
    logic [15:0]           mag;
    logic [DV_W:0]         trial;

    // constant sine magnitudes for the first quadrant
    for (genvar g = 0; g < QTR; g++) begin : g_qtab
        localparam logic [30:0] GX = 31'(g) << (30 - QW);
        localparam logic [14:0] QV = mfsk_pkg::quarter_sine(GX);
        assign qtab[g] = QV;
    end

    // fold the phase onto the first quadrant; the peak sits just past the table
    assign idx  = job.phase[31 -: mfsk_pkg::IDX_W];
    assign fold = idx[QW] ? QTR_V - {1'b0, idx[QW-1:0]} : {1'b0, idx[QW-1:0]};
    assign mq   = fold[QW] ? Q_TOP : qtab[fold[QW-1:0]];
    assign mag  = {1'b0, mq};
    assign trial = {rem_reg, quo_reg[DV_W-1]} - {16'd0, den_reg, 15'd0};

    assign job_ready = st_reg == B_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= B_IDLE;
            m_tvalid <= 1'b0;
        end else begin
            case (st_reg)
                B_IDLE: begin
                    if (job_valid) begin
                        neg_reg  <= idx[mfsk_pkg::IDX_W-1] && job.tone;
                        tone_reg <= job.tone;
                        last_reg <= job.last;
                        prod_reg <= 29'(mag) * 29'(mfsk_pkg::AMPL);
                        num_reg  <= job.num;
                        den_reg  <= job.den;
                        st_reg   <= B_MUL;
                    end
                end
                B_MUL: begin
                    quo_reg <= DV_W'(prod_reg) * DV_W'(num_reg);
                    rem_reg <= '0;
                    bit_reg <= 6'(DV_W);
                    st_reg  <= B_DIV;
                end
                B_DIV: begin
                    if (trial[DV_W]) begin
                        rem_reg <= {rem_reg[DV_W-2:0], quo_reg[DV_W-1]};
                        quo_reg <= {quo_reg[DV_W-2:0], 1'b0};
                    end else begin
                        rem_reg <= trial[DV_W-1:0];
                        quo_reg <= {quo_reg[DV_W-2:0], 1'b1};
                    end
                    bit_reg <= bit_reg - 6'd1;
                    if (bit_reg == 6'd1) st_reg <= B_OUT;
                end
                default: begin
                    if (!m_tvalid || m_tready) begin
                        m_sample <= !tone_reg ? 15'd0 :
                                    neg_reg ? 15'(-quo_reg[14:0]) : quo_reg[14:0];
                        m_last   <= last_reg;
                        m_tvalid <= 1'b1;
                        st_reg   <= B_IDLE;
                    end
                end
            endcase
            if (m_tvalid && m_tready && st_reg != B_OUT) m_tvalid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == B_OUT |-> quo_reg <= DV_W'(9000)) else $error("sample above full scale");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job_ready |=> st_reg == B_MUL) else $error("job not taken");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_sample))
        else $error("result dropped under stall");
`endif

endmodule
